// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker rtl
// expects clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never true outside reset
`define MRC_ASSERT_NEVER(lbl, cond, msg) \
  `MRC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/mrc_pkg.sv =====
// types, constants and crc step function for the modbus reply checker
// no dependencies
package mrc_pkg;

  localparam int RSP_LEN   = 15;
  localparam int DATA_LEN  = 10;
  localparam int HDR_LEN   = 3;
  localparam int STORE_END = HDR_LEN + DATA_LEN;
  localparam int IDX_W     = 5;
  localparam logic [IDX_W-1:0] IDX_MAX  = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RSP_LEN - 1);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  NODE_RST = 8'h01;
  localparam logic [6:0]  FUNC_RST = 7'h03;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LENGTH     = 3'd1,
    ST_NODE       = 3'd2,
    ST_EXCEPTION  = 3'd3,
    ST_FUNCTION   = 3'd4,
    ST_BYTE_COUNT = 3'd5,
    ST_CRC        = 3'd6
  } status_t;

  typedef enum logic {
    CFG_NODE = 1'b0,
    CFG_FUNC = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  exception_code;
    logic [15:0] level_mm;
    logic [15:0] range_mm;
    logic [15:0] offset_mm;
    logic [15:0] baud_code;
    logic [15:0] node_register;
  } result_t;

  // reflected crc-16, one byte unrolled
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrc_in_reg.sv =====
// input register stage for received request bytes
// depends on mrc_pkg
module mrc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrc_pkg::rx_item_t in_item,
  output logic              s1_valid,
  output mrc_pkg::rx_item_t s1_item,
  input  logic              s1_take
);
  import mrc_pkg::*;

  logic     valid_r, valid_nxt;
  rx_item_t item_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/mrc_frame_core.sv =====
// frame state, crc, byte stores and result decode
// depends on mrc_pkg and assert_macros.svh
`include "assert_macros.svh"

module mrc_frame_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mrc_pkg::rx_item_t item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  output logic              res_valid,
  output mrc_pkg::result_t  res
);
  import mrc_pkg::*;

  logic [7:0]       node_r;
  logic [6:0]       func_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [15:0]      crc_r;
  logic [15:0]      crc_nxt;
  logic [7:0]       td0_r;
  logic [7:0]       td1_r;
  logic [7:0]       hdr_r [HDR_LEN];
  logic [7:0]       data_r [DATA_LEN];
  logic [IDX_W-1:0] dofs;
  logic [15:0]      rx_crc;
  logic [15:0]      distance;
  logic [15:0]      rng;
  status_t          status;

  assign crc_nxt  = (idx_r >= IDX_W'(2)) ? crc_byte(crc_r, td1_r) : crc_r;
  assign idx_nxt  = (idx_r == IDX_MAX) ? idx_r : idx_r + IDX_W'(1);
  assign rx_crc   = {item.rx_byte, td0_r};
  assign dofs     = idx_r - IDX_W'(HDR_LEN);
  assign distance = {data_r[0], data_r[1]};
  assign rng      = {data_r[2], data_r[3]};

  always_comb begin
    if (idx_r != IDX_LAST) begin
      status = ST_LENGTH;
    end else if (hdr_r[0] != node_r) begin
      status = ST_NODE;
    end else if (hdr_r[1][7]) begin
      status = ST_EXCEPTION;
    end else if (hdr_r[1] != {1'b0, func_r}) begin
      status = ST_FUNCTION;
    end else if (hdr_r[2] != 8'(DATA_LEN)) begin
      status = ST_BYTE_COUNT;
    end else if (crc_nxt != rx_crc) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res                = '0;
    res.status         = status;
    res.exception_code = (status == ST_EXCEPTION) ? hdr_r[2] : 8'h00;
    if (status == ST_OK) begin
      res.level_mm      = rng - distance;
      res.range_mm      = rng;
      res.offset_mm     = {data_r[4], data_r[5]};
      res.baud_code     = {data_r[6], data_r[7]};
      res.node_register = {data_r[8], data_r[9]};
    end
  end

  assign res_valid = step && item.frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= NODE_RST;
      func_r <= FUNC_RST;
      idx_r  <= '0;
      crc_r  <= CRC_INIT;
      td0_r  <= '0;
      td1_r  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_index) == CFG_NODE) begin
          node_r <= cfg_wdata;
        end else begin
          func_r <= cfg_wdata[6:0];
        end
      end
      if (step) begin
        if (item.frame_end) begin
          idx_r <= '0;
          crc_r <= CRC_INIT;
          td0_r <= '0;
          td1_r <= '0;
        end else begin
          idx_r <= idx_nxt;
          crc_r <= crc_nxt;
          td0_r <= item.rx_byte;
          td1_r <= td0_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (idx_r < IDX_W'(HDR_LEN)) begin
        hdr_r[idx_r[1:0]] <= item.rx_byte;
      end else if (idx_r < IDX_W'(STORE_END)) begin
        data_r[dofs[3:0]] <= item.rx_byte;
      end
    end
  end

  `MRC_ASSERT(a_frame_clear,
    step && item.frame_end |=> idx_r == '0 && crc_r == CRC_INIT,
    "frame state not cleared after last byte")
  `MRC_ASSERT(a_idx_count,
    step && !item.frame_end && idx_r != IDX_MAX |=> idx_r == $past(idx_r) + IDX_W'(1),
    "byte index did not advance")
  `MRC_ASSERT(a_idle_hold,
    !step |=> $stable(crc_r) && $stable(idx_r),
    "frame state moved without a request")
  `MRC_ASSERT_NEVER(a_ok_len,
    res_valid && res.status == ST_OK && idx_r != IDX_LAST,
    "ok status on a frame of wrong length")
  `MRC_ASSERT_NEVER(a_exc_code,
    res_valid && res.status != ST_EXCEPTION && res.exception_code != 8'h00,
    "exception code without exception status")

endmodule

// ===== rtl/mrc_out_reg.sv =====
// result register between decode and the output channel
// depends on mrc_pkg
module mrc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mrc_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output mrc_pkg::result_t res_out
);
  import mrc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== rtl/modbus_read_response_checker.sv =====
// modbus rtu read holding registers reply checker, top level
// path: last byte held in the input register, result decoded from it and held in the result register
// throughput: one byte per cycle, unless the result register is full when a frame's last byte arrives
// reset: synchronous active low, clears frame state, sets node 1 and function 3
// depends on mrc_pkg, mrc_in_reg, mrc_frame_core, mrc_out_reg
module modbus_read_response_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_exception_code,
  output logic [15:0]        out_level_mm,
  output logic [15:0]        out_range_mm,
  output logic signed [15:0] out_offset_mm,
  output logic [15:0]        out_baud_code,
  output logic [15:0]        out_node_register,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import mrc_pkg::*;

  rx_item_t in_item;
  rx_item_t s1_item;
  logic     s1_valid;
  logic     s1_take;
  logic     can_load;
  logic     res_valid;
  result_t  res;
  result_t  res_out;

  assign in_item.rx_byte   = in_rx_byte;
  assign in_item.frame_end = in_frame_end;
  assign s1_take = s1_valid && (!s1_item.frame_end || can_load);

  mrc_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  mrc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_take),
    .item      (s1_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  mrc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_status         = res_out.status;
  assign out_exception_code = res_out.exception_code;
  assign out_level_mm       = res_out.level_mm;
  assign out_range_mm       = res_out.range_mm;
  assign out_offset_mm      = $signed(res_out.offset_mm);
  assign out_baud_code      = res_out.baud_code;
  assign out_node_register  = res_out.node_register;

endmodule

// ===== tb/modbus_read_response_checker_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for modbus_read_response_checker: drives reply frames
// byte by byte and checks each result against an in-bench frame decoder
// depends on mrc_pkg and the dut
module modbus_read_response_checker_test;
  import mrc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_exception_code;
  logic [15:0] out_level_mm;
  logic [15:0] out_range_mm;
  logic signed [15:0] out_offset_mm;
  logic [15:0] out_baud_code;
  logic [15:0] out_node_register;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_wdata = '0;

  modbus_read_response_checker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_exception_code(out_exception_code),
    .out_level_mm(out_level_mm),
    .out_range_mm(out_range_mm),
    .out_offset_mm(out_offset_mm),
    .out_baud_code(out_baud_code),
    .out_node_register(out_node_register),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // frame decoder state
  logic [7:0] exp_node = NODE_RST;
  logic [6:0] exp_func = FUNC_RST;
  logic [4:0] fr_count = '0;
  logic [15:0] fr_crc = CRC_INIT;
  logic [7:0] fr_hdr[3];
  logic [7:0] fr_data[10];
  logic [7:0] fr_delay[2] = '{8'h00, 8'h00};

  rx_item_t rx_byte_q[$];
  result_t reply_expect_q[$];
  result_t want_reply;
  rx_item_t cur_req;

  bit req_accepted = 1'b0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int bytes_queued = 0;
  int mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_of(input byte_q_t bytes);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (bytes[i]) c = crc16_step(c, bytes[i]);
    return c;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    logic [15:0] sent_crc;
    logic [15:0] distance;
    result_t r;
    pos = fr_count;
    if (pos >= 2) fr_crc = crc16_step(fr_crc, fr_delay[1]);
    fr_delay[1] = fr_delay[0];
    fr_delay[0] = b;
    if (pos < HDR_LEN) fr_hdr[pos] = b;
    else if (pos < STORE_END) fr_data[pos - HDR_LEN] = b;
    if (fr_count != IDX_MAX) fr_count = fr_count + 5'd1;
    if (last) begin
      r = '0;
      sent_crc = {fr_delay[0], fr_delay[1]};
      if (fr_count != 5'(RSP_LEN)) r.status = ST_LENGTH;
      else if (fr_hdr[0] != exp_node) r.status = ST_NODE;
      else if (fr_hdr[1][7]) begin
        r.status = ST_EXCEPTION;
        r.exception_code = fr_hdr[2];
      end else if (fr_hdr[1] != {1'b0, exp_func}) r.status = ST_FUNCTION;
      else if (fr_hdr[2] != 8'(DATA_LEN)) r.status = ST_BYTE_COUNT;
      else if (fr_crc != sent_crc) r.status = ST_CRC;
      else begin
        r.status = ST_OK;
        distance = {fr_data[0], fr_data[1]};
        r.range_mm = {fr_data[2], fr_data[3]};
        r.level_mm = r.range_mm - distance;
        r.offset_mm = {fr_data[4], fr_data[5]};
        r.baud_code = {fr_data[6], fr_data[7]};
        r.node_register = {fr_data[8], fr_data[9]};
      end
      reply_expect_q.push_back(r);
      fr_count = '0;
      fr_crc = CRC_INIT;
      fr_delay[0] = 8'h00;
      fr_delay[1] = 8'h00;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    req_accepted = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      req_accepted = 1'b1;
      absorb_byte(in_rx_byte, in_frame_end);
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_byte_q.size() != 0) begin
        cur_req = rx_byte_q.pop_front();
        in_valid <= 1'b1;
        in_rx_byte <= cur_req.rx_byte;
        in_frame_end <= cur_req.frame_end;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap(out_calm);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reply_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_status, 16'h0000);
      end else begin
        want_reply = reply_expect_q.pop_front();
        check_field("status", out_status, want_reply.status);
        check_field("exception_code", out_exception_code, want_reply.exception_code);
        check_field("level_mm", out_level_mm, want_reply.level_mm);
        check_field("range_mm", out_range_mm, want_reply.range_mm);
        check_field("offset_mm", out_offset_mm, want_reply.offset_mm);
        check_field("baud_code", out_baud_code, want_reply.baud_code);
        check_field("node_register", out_node_register, want_reply.node_register);
      end
    end
  end

  task automatic queue_frame(input byte_q_t bytes);
    rx_item_t it;
    foreach (bytes[i]) begin
      it.rx_byte = bytes[i];
      it.frame_end = (i == bytes.size() - 1);
      rx_byte_q.push_back(it);
      bytes_queued++;
    end
  endtask

  task automatic seal_and_send(input byte_q_t body, input bit spoil);
    logic [15:0] c;
    c = crc_of(body);
    if (spoil) c = c ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    queue_frame(body);
  endtask

  function automatic byte_q_t reply_body(input logic [7:0] node, input logic [7:0] func,
                                         input logic [7:0] count);
    byte_q_t body;
    int r;
    body.push_back(node);
    body.push_back(func);
    body.push_back(count);
    repeat (DATA_LEN) begin
      r = $urandom_range(0, 9);
      body.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
    end
    return body;
  endfunction

  task automatic queue_random_frame();
    int kind;
    int len;
    logic [6:0] f;
    logic [7:0] cnt;
    logic [15:0] c;
    byte_q_t body;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      seal_and_send(reply_body(exp_node, {1'b0, exp_func}, 8'(DATA_LEN)), 1'b0);
    end else if (kind < 63) begin
      seal_and_send(reply_body(exp_node, {1'b0, exp_func}, 8'(DATA_LEN)), 1'b1);
    end else if (kind < 69) begin
      seal_and_send(reply_body(exp_node ^ 8'($urandom_range(1, 255)), 8'($urandom),
                               8'($urandom_range(9, 11))), 1'b0);
    end else if (kind < 76) begin
      seal_and_send(reply_body(exp_node, {1'b1, 7'($urandom)}, 8'($urandom)),
                    1'($urandom));
    end else if (kind < 81) begin
      do f = 7'($urandom); while (f == exp_func);
      seal_and_send(reply_body(exp_node, {1'b0, f}, 8'(DATA_LEN)), 1'($urandom));
    end else if (kind < 86) begin
      cnt = 8'($urandom);
      if (cnt == 8'(DATA_LEN)) cnt = 8'(DATA_LEN - 1);
      seal_and_send(reply_body(exp_node, {1'b0, exp_func}, cnt), 1'($urandom));
    end else begin
      if (kind < 96) len = $urandom_range(0, 1) ? $urandom_range(1, RSP_LEN - 1)
                                                 : $urandom_range(RSP_LEN + 1, 45);
      else len = RSP_LEN;
      body.delete();
      if (kind < 96 && $urandom_range(0, 9) < 7) begin
        body = reply_body(exp_node, {1'b0, exp_func}, 8'(DATA_LEN));
        c = crc_of(body);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
      end
      while (body.size() > len) void'(body.pop_back());
      while (body.size() < len) body.push_back(8'($urandom));
      queue_frame(body);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(rx_byte_q.size() == 0 && (!in_valid || req_accepted)
             && reply_expect_q.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_NODE) exp_node = val;
    else exp_func = val[6:0];
  endtask

  initial begin
    #2000000;
    $display("[modbus_read_response_checker] ERROR");
    $finish;
  end

  initial begin
    byte_q_t body;
    logic [79:0] wrap_data;
    int phase_end;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // well-formed reply with level wrap and offset at its negative limit
    wrap_data = 80'hFFFF_0000_8000_FFFF_0000;
    body = reply_body(exp_node, {1'b0, exp_func}, 8'(DATA_LEN));
    for (int i = 0; i < DATA_LEN; i++) body[HDR_LEN + i] = wrap_data[79 - 8 * i -: 8];
    seal_and_send(body, 1'b0);
    // single byte frame
    body.delete();
    body.push_back(8'hFF);
    queue_frame(body);
    // short exception reply
    body.delete();
    body.push_back(exp_node);
    body.push_back(8'h83);
    body.push_back(8'h02);
    seal_and_send(body, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            write_cfg(CFG_NODE, 8'h00);
            write_cfg(CFG_FUNC, 8'h00);
          end
          2: begin
            write_cfg(CFG_NODE, 8'hFF);
            write_cfg(CFG_FUNC, 8'hFF);
          end
          default: begin
            write_cfg(CFG_NODE, 8'($urandom));
            write_cfg(CFG_FUNC, 8'($urandom));
          end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      if (ph == 2) hold_requests++;
      phase_end = bytes_queued + 200;
      while (bytes_queued < phase_end) queue_random_frame();
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("[modbus_read_response_checker] OK");
    end else begin
      $display("[modbus_read_response_checker] ERROR");
    end
    $finish;
  end

endmodule

// ===== modbus_read_response_checker.f =====
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_in_reg.sv
rtl/mrc_frame_core.sv
rtl/mrc_out_reg.sv
rtl/modbus_read_response_checker.sv
tb/modbus_read_response_checker_test.sv
